### rtl/priority_thread_scheduler_macros.svh
// Assertion macros for the scheduler.
`ifndef PRIORITY_THREAD_SCHEDULER_MACROS_SVH
`define PRIORITY_THREAD_SCHEDULER_MACROS_SVH
`ifndef SYNTH
`define PTS_NEVER(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`define PTS_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`else
`define PTS_NEVER(label, expr, msg)
`define PTS_IMPLY(label, ante, cons, msg)
`endif
`endif

### rtl/pts_pkg.sv
`default_nettype none
package pts_pkg;
  localparam int THREADS_DEF = 16;

  localparam logic [3:0] K_CREATE  = 4'd0;
  localparam logic [3:0] K_START   = 4'd1;
  localparam logic [3:0] K_DELETE  = 4'd2;
  localparam logic [3:0] K_WAIT    = 4'd3;
  localparam logic [3:0] K_TRIGGER = 4'd4;
  localparam logic [3:0] K_WAKEUP  = 4'd5;
  localparam logic [3:0] K_SLEEP   = 4'd6;
  localparam logic [3:0] K_EXIT    = 4'd7;
  localparam logic [3:0] K_PRIO    = 4'd8;
  localparam logic [3:0] K_RESCHED = 4'd9;
  localparam logic [3:0] K_WAITEND = 4'd10;

  localparam logic [5:0] ST_READY   = 6'd2;
  localparam logic [5:0] ST_WAIT    = 6'd4;
  localparam logic [5:0] ST_SUSPEND = 6'd8;
  localparam logic [5:0] ST_DORMANT = 6'd16;

  localparam logic [3:0] WK_SLEEP     = 4'd1;
  localparam logic [3:0] WK_THREADEND = 4'd9;

  localparam logic [2:0] RC_OK      = 3'd0;
  localparam logic [2:0] RC_UNKNOWN = 3'd1;
  localparam logic [2:0] RC_NOTDORM = 3'd2;
  localparam logic [2:0] RC_SELF    = 3'd3;
  localparam logic [2:0] RC_NOREADY = 3'd4;

  typedef struct packed {
    logic        used_en;
    logic        used;
    logic        state_en;
    logic [5:0]  state;
    logic        prio_en;
    logic [6:0]  prio;
    logic        wait_en;
    logic [3:0]  wkind;
    logic [15:0] wobj;
    logic        wc_en;
    logic [7:0]  wc;
  } pts_wr_t;

  typedef struct packed {
    logic        used;
    logic [5:0]  state;
    logic [6:0]  prio;
    logic [3:0]  wkind;
    logic [15:0] wobj;
    logic [7:0]  wc;
  } pts_rd_t;
endpackage
`default_nettype wire

### rtl/priority_thread_scheduler.sv
// channel | dir | tdata fields (low bit up)
// s_*     | in  | kind, thread_slot, use_current, priority_req, wait_kind, object_id, no_switch
// m_*     | out | result_code, running_slot, running_valid, switched
// One command at a time: a single table access, then up to two walks over the
// slot table (wait match, then pick) at one slot per cycle through the one table
// port. Sync reset clears the used bits and the running slot. Result waits in the
// output register until m_tready.
`default_nettype none
`include "priority_thread_scheduler_macros.svh"
module priority_thread_scheduler import pts_pkg::*; #(
  parameter int THREADS = THREADS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [39:0] s_tdata,  // kind, thread_slot, use_current, priority_req,
                                     // wait_kind, object_id, no_switch, zero fill
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata   // result_code, running_slot, running_valid,
                                     // switched, zero fill
);
  localparam int SW = $clog2(THREADS);
  localparam logic [2:0] S_IDLE = 3'd0, S_SINGLE = 3'd1, S_WCUR = 3'd2,
                         S_TRIG = 3'd3, S_RESCH = 3'd4, S_OUT = 3'd5;

  logic [2:0]    st;
  logic [SW-1:0] ptr, cnt, run, orun, best;
  logic          pres, opres, found, nosw;
  logic [3:0]    kind, slot, tk;
  logic [6:0]    prio_r, bestp;
  logic [15:0]   tobj;
  logic [2:0]    code;
  pts_wr_t       wr;
  pts_rd_t       rd;

  wire logic [3:0]  in_kind = s_tdata[3:0];
  wire logic [3:0]  in_slot = s_tdata[7:4];
  wire logic        in_cur  = s_tdata[8];
  wire logic [6:0]  in_prio = s_tdata[15:9];
  wire logic [3:0]  in_wk   = s_tdata[19:16];
  wire logic [15:0] in_obj  = s_tdata[35:20];
  wire logic        in_nosw = s_tdata[36];
  wire logic        in_rng  = 32'(in_slot) < THREADS;
  wire logic [SW-1:0] in_idx = SW'(in_slot);
  wire logic        in_self = pres && in_rng && in_idx == run;
  wire logic        last = cnt == SW'(THREADS - 1);

  function automatic logic [SW-1:0] nxt(input logic [SW-1:0] p);
    return (p == SW'(THREADS - 1)) ? '0 : p + 1'b1;
  endfunction

  pts_table #(.THREADS(THREADS)) u_table (.clk, .rst, .ptr, .wr, .rd);

  logic [7:0] wc_inc, wc_dec;
  logic [5:0] wake_st, trig_st;
  always_comb begin
    wc_inc  = (rd.wc == 8'h7f) ? rd.wc : rd.wc + 8'd1;
    wc_dec  = (rd.wc == 8'h80) ? rd.wc : rd.wc - 8'd1;
    wake_st = rd.state & ~ST_WAIT;
    if ((wake_st & ST_SUSPEND) == 6'd0) wake_st = wake_st | ST_READY;
    trig_st = rd.state & ~ST_WAIT;
    if (trig_st == 6'd0) trig_st = ST_READY;
  end

  // table write for the current step
  always_comb begin
    wr = '0;
    case (st)
      S_SINGLE: begin
        case (kind)
          K_CREATE: begin
            wr.used_en = 1'b1; wr.used = 1'b1;
            wr.state_en = 1'b1; wr.state = ST_DORMANT;
            wr.prio_en = 1'b1; wr.prio = prio_r;
            wr.wait_en = 1'b1; wr.wc_en = 1'b1;
          end
          K_START: begin
            wr.state_en = rd.used && rd.state == ST_DORMANT;
            wr.state = ST_READY;
          end
          K_DELETE: begin
            wr.used_en = rd.used;
          end
          K_WAKEUP: begin
            wr.wc_en = rd.used; wr.wc = wc_inc;
            wr.state_en = rd.used && rd.wkind == WK_SLEEP && !wc_inc[7];
            wr.state = wake_st;
          end
          K_SLEEP: begin
            wr.wc_en = 1'b1; wr.wc = wc_dec;
          end
          K_EXIT: begin
            wr.state_en = 1'b1; wr.state = ST_DORMANT;
          end
          K_PRIO: begin
            wr.prio_en = rd.used; wr.prio = prio_r;
          end
          default: ;
        endcase
      end
      S_WCUR: begin
        wr.state_en = 1'b1; wr.state = ST_WAIT;
        wr.wait_en = 1'b1; wr.wkind = tk; wr.wobj = tobj;
      end
      S_TRIG: begin
        wr.state_en = rd.used && (rd.state & ST_WAIT) != 6'd0 &&
                      rd.wkind == tk && rd.wobj == tobj;
        wr.state = trig_st;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE; pres <= 1'b0; run <= '0;
    end else begin
      case (st)
        S_IDLE: if (s_tvalid) begin
          kind <= in_kind; slot <= in_slot; prio_r <= in_prio;
          tk <= in_wk; tobj <= in_obj; nosw <= in_nosw && in_kind == K_TRIGGER;
          orun <= run; opres <= pres; code <= RC_OK; ptr <= in_idx;
          cnt <= '0; found <= 1'b0;
          st <= S_OUT;
          case (in_kind)
            K_CREATE, K_START, K_DELETE: begin
              if (in_self) code <= RC_SELF;
              else if (!in_rng) code <= RC_UNKNOWN;
              else st <= S_SINGLE;
            end
            K_WAIT: begin
              if (!pres) code <= RC_UNKNOWN;
              else begin ptr <= run; st <= S_WCUR; end
            end
            K_TRIGGER: begin ptr <= '0; st <= S_TRIG; end
            K_WAKEUP, K_WAITEND: if (in_rng) st <= S_SINGLE;
            K_SLEEP, K_EXIT: begin
              if (!pres) code <= RC_UNKNOWN;
              else begin ptr <= run; st <= S_SINGLE; end
            end
            K_PRIO: begin
              if (in_cur) begin
                if (!pres) code <= RC_UNKNOWN;
                else begin ptr <= run; st <= S_SINGLE; end
              end else if (!in_rng) code <= RC_UNKNOWN;
              else st <= S_SINGLE;
            end
            K_RESCHED: begin ptr <= nxt(pres ? run : '0); st <= S_RESCH; end
            default: ;
          endcase
        end
        S_SINGLE: begin
          st <= S_OUT;
          case (kind)
            K_START: begin
              if (!rd.used) code <= RC_UNKNOWN;
              else if (rd.state != ST_DORMANT) code <= RC_NOTDORM;
            end
            K_DELETE: begin
              if (!rd.used) code <= RC_UNKNOWN;
              else begin
                tk <= WK_THREADEND; tobj <= 16'(slot); ptr <= '0; st <= S_TRIG;
              end
            end
            K_SLEEP: if (wc_dec[7]) begin
              tk <= WK_SLEEP; tobj <= '0; st <= S_WCUR;
            end
            K_EXIT: begin
              tk <= WK_THREADEND; tobj <= 16'(run); ptr <= '0; st <= S_TRIG;
            end
            K_PRIO: if (!rd.used) code <= RC_UNKNOWN;
            K_WAITEND: if (rd.used && rd.state != ST_DORMANT) begin
              if (!pres) code <= RC_UNKNOWN;
              else begin
                tk <= WK_THREADEND; tobj <= 16'(slot); ptr <= run; st <= S_WCUR;
              end
            end
            default: ;
          endcase
        end
        S_WCUR: begin
          ptr <= nxt(run); cnt <= '0; found <= 1'b0; st <= S_RESCH;
        end
        S_TRIG: begin
          ptr <= nxt(ptr); cnt <= cnt + 1'b1;
          if (last) begin
            cnt <= '0; found <= 1'b0;
            if (nosw) st <= S_OUT;
            else begin ptr <= nxt(pres ? run : '0); st <= S_RESCH; end
          end
        end
        S_RESCH: begin
          // strict compare keeps the first hit after the running slot
          if (rd.used && (rd.state & ST_READY) != 6'd0 && (!found || rd.prio < bestp)) begin
            found <= 1'b1; best <= ptr; bestp <= rd.prio;
          end
          ptr <= nxt(ptr); cnt <= cnt + 1'b1;
          if (last) begin
            st <= S_OUT;
            if (rd.used && (rd.state & ST_READY) != 6'd0 && (!found || rd.prio < bestp)) begin
              run <= ptr; pres <= 1'b1;
            end else if (found) begin
              run <= best; pres <= 1'b1;
            end else code <= RC_NOREADY;
          end
        end
        S_OUT: if (m_tready) st <= S_IDLE;
        default: st <= S_IDLE;
      endcase
    end
  end

  wire logic sw = (pres != opres) || (pres && run != orun);
  assign s_tready = st == S_IDLE;
  assign m_tvalid = st == S_OUT;
  assign m_tdata  = {7'd0, sw, pres, 4'(run), code};

  `PTS_NEVER(a_one_side, s_tready && m_tvalid, "accepting while result pending")
  `PTS_IMPLY(a_sw_run, m_tvalid && m_tdata[8], m_tdata[7], "switched with nothing running")
  `PTS_IMPLY(a_code, m_tvalid, m_tdata[2:0] <= RC_NOREADY, "bad result code")
  `PTS_IMPLY(a_run_keep, !rst && $past(pres) && !rst, pres, "running thread lost")
endmodule
`default_nettype wire

### rtl/pts_table.sv
`default_nettype none
module pts_table import pts_pkg::*; #(
  parameter int THREADS = THREADS_DEF,
  localparam int SW = $clog2(THREADS)
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic [SW-1:0] ptr,
  input  wire pts_wr_t       wr,
  output pts_rd_t            rd
);
  logic [THREADS-1:0] used;
  logic [5:0]  state [THREADS];
  logic [6:0]  prio  [THREADS];
  logic [3:0]  wkind [THREADS];
  logic [15:0] wobj  [THREADS];
  logic [7:0]  wc    [THREADS];

  always_ff @(posedge clk) begin
    if (rst) begin
      used <= '0;
    end else if (wr.used_en) begin
      used[ptr] <= wr.used;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.state_en) state[ptr] <= wr.state;
    if (wr.prio_en) prio[ptr] <= wr.prio;
    if (wr.wait_en) begin
      wkind[ptr] <= wr.wkind;
      wobj[ptr]  <= wr.wobj;
    end
    if (wr.wc_en) wc[ptr] <= wr.wc;
  end

  always_comb begin
    rd.used  = used[ptr];
    rd.state = state[ptr];
    rd.prio  = prio[ptr];
    rd.wkind = wkind[ptr];
    rd.wobj  = wobj[ptr];
    rd.wc    = wc[ptr];
  end
endmodule
`default_nettype wire

### bench/priority_thread_scheduler_tb.sv
`timescale 1ns / 1ps
`default_nettype none
module priority_thread_scheduler_tb;
  import pts_pkg::*;

  localparam int NSLOT = 16;
  localparam int WATCH_LIMIT = 20000;
  localparam logic [3:0] K_BAD = 4'd15;

  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  slot;
    logic        use_cur;
    logic [6:0]  prio;
    logic [3:0]  wkind;
    logic [15:0] obj;
    logic        nosw;
  } cmd_t;

  // msb first: matches m_tdata[8:0]
  typedef struct packed {
    logic       switched;
    logic       run_valid;
    logic [3:0] run_slot;
    logic [2:0] code;
  } sched_resp_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [39:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [15:0] m_tdata;

  priority_thread_scheduler uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #5 clk = ~clk;

  // shadow thread table
  logic       sh_used[NSLOT];
  logic [5:0] sh_state[NSLOT];
  logic [6:0] sh_prio[NSLOT];
  logic [3:0] sh_wkind[NSLOT];
  logic [15:0] sh_wobj[NSLOT];
  logic signed [7:0] sh_wc[NSLOT];
  logic [3:0] sh_run;
  logic       sh_present;

  cmd_t pending_cmds[$];
  sched_resp_t expected_resp[$];
  int errors = 0;
  int idle_cycles = 0;
  int sent_cnt = 0;
  bit in_taken = 1'b0;
  wire logic quiet_phase = sent_cnt >= 400 && sent_cnt < 650;
  bit hold_sender = 1'b0;
  bit stim_done = 1'b0;

  function automatic void add_cmd(cmd_t c);
    pending_cmds.insert(pending_cmds.size(), c);
  endfunction

  function automatic logic [2:0] pick_next();
    logic [3:0] idx;
    logic [3:0] best;
    int bestp;
    logic found;
    idx = sh_present ? sh_run : 4'd0;
    best = '0;
    bestp = 1 << 24;
    found = 1'b0;
    for (int i = 0; i < NSLOT; i++) begin
      idx = idx + 4'd1;
      if (sh_used[idx] && int'(sh_prio[idx]) < bestp && (sh_state[idx] & ST_READY) != 0) begin
        best = idx;
        bestp = sh_prio[idx];
        found = 1'b1;
      end
    end
    if (!found) return RC_NOREADY;
    sh_run = best;
    sh_present = 1'b1;
    return RC_OK;
  endfunction

  function automatic logic [2:0] release_waiters(logic [3:0] k, logic [15:0] o, logic nosw);
    for (int i = 0; i < NSLOT; i++) begin
      if (sh_used[i] && (sh_state[i] & ST_WAIT) != 0 && sh_wkind[i] == k && sh_wobj[i] == o) begin
        sh_state[i] = sh_state[i] & ~ST_WAIT;
        if (sh_state[i] == 0) sh_state[i] = ST_READY;
      end
    end
    return nosw ? RC_OK : pick_next();
  endfunction

  function automatic logic [2:0] block_current(logic [3:0] k, logic [15:0] o);
    sh_state[sh_run] = ST_WAIT;
    sh_wkind[sh_run] = k;
    sh_wobj[sh_run] = o;
    return pick_next();
  endfunction

  function automatic logic known(logic [3:0] s);
    return sh_used[s];
  endfunction

  function automatic sched_resp_t predict_sched(cmd_t c);
    logic [2:0] code;
    logic [3:0] old_run;
    logic old_pres, self_hit;
    logic [3:0] s;
    logic [5:0] t;
    sched_resp_t r;
    code = RC_OK;
    old_run = sh_run;
    old_pres = sh_present;
    s = c.slot;
    self_hit = sh_present && s == sh_run;
    case (c.kind)
      K_CREATE: begin
        if (self_hit) code = RC_SELF;
        else begin
          sh_used[s] = 1'b1; sh_state[s] = ST_DORMANT; sh_prio[s] = c.prio;
          sh_wkind[s] = '0; sh_wobj[s] = '0; sh_wc[s] = '0;
        end
      end
      K_START: begin
        if (self_hit) code = RC_SELF;
        else if (!known(s)) code = RC_UNKNOWN;
        else if (sh_state[s] != ST_DORMANT) code = RC_NOTDORM;
        else sh_state[s] = ST_READY;
      end
      K_DELETE: begin
        if (self_hit) code = RC_SELF;
        else if (!known(s)) code = RC_UNKNOWN;
        else begin
          sh_used[s] = 1'b0;
          code = release_waiters(WK_THREADEND, {12'd0, s}, 1'b0);
        end
      end
      K_WAIT: code = !sh_present ? RC_UNKNOWN : block_current(c.wkind, c.obj);
      K_TRIGGER: code = release_waiters(c.wkind, c.obj, c.nosw);
      K_WAKEUP: begin
        if (known(s)) begin
          if (sh_wc[s] != 8'sd127) sh_wc[s] = sh_wc[s] + 8'sd1;
          if (sh_wkind[s] == WK_SLEEP && sh_wc[s] >= 0) begin
            t = sh_state[s] & ~ST_WAIT;
            if ((t & (ST_SUSPEND | ST_WAIT)) == 0) t = t | ST_READY;
            sh_state[s] = t;
          end
        end
      end
      K_SLEEP: begin
        if (!sh_present) code = RC_UNKNOWN;
        else begin
          if (sh_wc[sh_run] != -8'sd128) sh_wc[sh_run] = sh_wc[sh_run] - 8'sd1;
          if (sh_wc[sh_run] < 0) code = block_current(WK_SLEEP, 16'd0);
        end
      end
      K_EXIT: begin
        if (!sh_present) code = RC_UNKNOWN;
        else begin
          sh_state[sh_run] = ST_DORMANT;
          code = release_waiters(WK_THREADEND, {12'd0, sh_run}, 1'b0);
        end
      end
      K_PRIO: begin
        if (c.use_cur && !sh_present) code = RC_UNKNOWN;
        else begin
          if (c.use_cur) s = sh_run;
          if (!known(s)) code = RC_UNKNOWN;
          else sh_prio[s] = c.prio;
        end
      end
      K_RESCHED: code = pick_next();
      K_WAITEND: begin
        if (known(s) && sh_state[s] != ST_DORMANT) begin
          if (!sh_present) code = RC_UNKNOWN;
          else code = block_current(WK_THREADEND, {12'd0, s});
        end
      end
      default: ;
    endcase
    r.code = code;
    r.run_slot = sh_run;
    r.run_valid = sh_present;
    r.switched = (sh_present != old_pres) || (sh_present && sh_run != old_run);
    return r;
  endfunction

  function automatic logic [39:0] pack_cmd(cmd_t c);
    return {3'b000, c.nosw, c.obj, c.wkind, c.prio, c.use_cur, c.slot, c.kind};
  endfunction

  function automatic logic rnd_idle();
    return !quiet_phase && $urandom_range(99) < 35;
  endfunction

  // input handshake seen at the last rising edge
  always @(posedge clk) begin
    in_taken <= s_tvalid && s_tready;
  end

  // driver
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || in_taken) begin
      // previous item taken (or none offered): choose the next one
      if (pending_cmds.size() != 0 && !hold_sender && !rnd_idle()) begin
        s_tdata <= pack_cmd(pending_cmds[0]);
        expected_resp.insert(expected_resp.size(), predict_sched(pending_cmds.pop_front()));
        sent_cnt <= sent_cnt + 1;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
        s_tdata <= 40'({$urandom, $urandom});
      end
    end
  end

  // sink stall
  always @(negedge clk) begin
    m_tready <= !rst && !rnd_idle();
  end

  // monitor
  always @(posedge clk) begin
    sched_resp_t got, exp_r;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[8:0];
      if (expected_resp.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected result %h", got);
      end else begin
        exp_r = expected_resp.pop_front();
        if (got !== exp_r || m_tdata[15:9] !== 7'd0) begin
          errors++;
          if (errors <= 10)
            $display({"mismatch: expected code %0d slot %0d valid %0b sw %0b,",
                      " got code %0d slot %0d valid %0b sw %0b"},
                     exp_r.code, exp_r.run_slot, exp_r.run_valid, exp_r.switched,
                     got.code, got.run_slot, got.run_valid, got.switched);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic cmd_t mk(logic [3:0] k, logic [3:0] s, logic [6:0] p);
    cmd_t c;
    c = '0;
    c.kind = k; c.slot = s; c.prio = p;
    c.wkind = 4'($urandom); c.obj = 16'($urandom);
    c.nosw = 1'($urandom); c.use_cur = 1'($urandom);
    return c;
  endfunction

  function automatic cmd_t rand_cmd();
    cmd_t c;
    int r;
    c = mk(4'($urandom_range(10)), 4'($urandom), 7'($urandom));
    r = $urandom_range(99);
    if (r < 4) c.kind = 4'($urandom_range(15, 11));
    // narrow waits onto few objects so triggers hit
    if ($urandom_range(99) < 80) begin
      c.wkind = ($urandom_range(3) == 0) ? WK_SLEEP : 4'($urandom_range(3));
      c.obj = 16'($urandom_range(3));
      if (c.kind == K_TRIGGER && $urandom_range(3) == 0) begin
        c.wkind = WK_THREADEND;
        c.obj = 16'($urandom_range(15));
      end
    end
    if ($urandom_range(99) < 70) c.prio = 7'($urandom_range(7));
    return c;
  endfunction

  initial begin
    cmd_t c;
    for (int i = 0; i < NSLOT; i++) begin
      sh_used[i] = '0; sh_state[i] = '0; sh_prio[i] = '0;
      sh_wkind[i] = '0; sh_wobj[i] = '0; sh_wc[i] = '0;
    end
    sh_run = '0;
    sh_present = 1'b0;
    // directed: idle scheduler corner cases, then extremes
    add_cmd(mk(K_RESCHED, 4'd0, 7'd0));
    add_cmd(mk(K_SLEEP, 4'd0, 7'd0));
    add_cmd(mk(K_EXIT, 4'd0, 7'd0));
    c = mk(K_WAIT, 4'd0, 7'd0); add_cmd(c);
    c = mk(K_PRIO, 4'd3, 7'd5); c.use_cur = 1'b1; add_cmd(c);
    add_cmd(mk(K_WAKEUP, 4'd9, 7'd0));
    add_cmd(mk(K_START, 4'd9, 7'd0));
    add_cmd(mk(K_CREATE, 4'd0, 7'd127));
    add_cmd(mk(K_CREATE, 4'd15, 7'd0));
    add_cmd(mk(K_CREATE, 4'd7, 7'd0));
    add_cmd(mk(K_WAITEND, 4'd0, 7'd0));
    add_cmd(mk(K_START, 4'd15, 7'd0));
    add_cmd(mk(K_START, 4'd15, 7'd0));
    add_cmd(mk(K_START, 4'd7, 7'd0));
    add_cmd(mk(K_RESCHED, 4'd0, 7'd0));
    add_cmd(mk(K_RESCHED, 4'd0, 7'd0));
    add_cmd(mk(K_START, 4'd0, 7'd0));
    add_cmd(mk(K_WAITEND, 4'd0, 7'd0));
    add_cmd(mk(K_CREATE, sh_run, 7'd1));
    add_cmd(mk(K_SLEEP, 4'd0, 7'd0));
    add_cmd(mk(K_WAKEUP, 4'd15, 7'd0));
    add_cmd(mk(K_DELETE, 4'd0, 7'd0));
    add_cmd(mk(K_EXIT, 4'd0, 7'd0));
    c = mk(K_TRIGGER, 4'd0, 7'd0); c.wkind = 4'hf; c.obj = 16'hffff; add_cmd(c);
    add_cmd(mk(K_BAD, 4'd0, 7'd0));
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    wait (pending_cmds.size() == 0);
    hold_sender = 1'b1;
    wait (expected_resp.size() == 0);
    hold_sender = 1'b0;
    for (int n = 0; n < 1045; n++) begin
      // random commands, some forced to create or start, and one burst of saturation tests
      c = rand_cmd();
      if ($urandom_range(9) == 0) c.kind = $urandom_range(1) ? K_CREATE : K_START;
      add_cmd(c);
      if (n == 700) begin
        // long sleep/wakeup runs reach both saturation limits
        for (int j = 0; j < 140; j++) add_cmd(mk(K_WAKEUP, 4'd3, 7'd0));
        for (int j = 0; j < 140; j++) add_cmd(mk(K_SLEEP, 4'd0, 7'd0));
      end
      if (n == 900) begin
        wait (pending_cmds.size() == 0);
        hold_sender = 1'b1;
        wait (expected_resp.size() == 0);
        hold_sender = 1'b0;
      end
    end
    wait (pending_cmds.size() == 0);
    wait (expected_resp.size() == 0);
    repeat (50) @(posedge clk);
    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end
endmodule
`default_nettype wire

### files.f
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_table.sv
rtl/priority_thread_scheduler.sv
bench/priority_thread_scheduler_tb.sv
